// ===== hw/rtl/weighted_union_find_macros.svh =====
// ----------------------------------------------------------------------------
// weighted_union_find_macros.svh
// Assertion macros for the weighted union-find engine. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_UNION_FIND_MACROS_SVH
`define WEIGHTED_UNION_FIND_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset
`define WUF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("weighted_union_find: same-cycle check failed");
// Next-cycle implication, disabled while in reset
`define WUF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("weighted_union_find: next-cycle check failed");
`else
`define WUF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WUF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/wuf_pkg.sv =====
// ----------------------------------------------------------------------------
// wuf_pkg
// Shared constants and types of the weighted union-find engine.
// ----------------------------------------------------------------------------
package wuf_pkg;

  // Default number of elements in the forest
  localparam int unsigned ELEMENT_COUNT_DEF = 1024;

  // Width of one element index field on the input stream
  localparam int unsigned FIELD_W = 10;

  // Stream data widths (fields padded to whole bytes)
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 8;

  // Operation codes carried in tuser
  localparam logic OP_CONNECT = 1'b0;
  localparam logic OP_FIND    = 1'b1;

  // Result of the shared compare unit
  typedef struct packed {
    logic eq;  // operands equal
    logic lt;  // first operand below second
  } cmp_res_t;

endpackage

// ===== hw/rtl/wuf_ram.sv =====
// ----------------------------------------------------------------------------
// wuf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wuf_ram #(
  parameter int unsigned DEPTH = wuf_pkg::ELEMENT_COUNT_DEF,
  parameter int unsigned WIDTH = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/wuf_cmp.sv =====
// ----------------------------------------------------------------------------
// wuf_cmp
// Shared compare unit: equality and unsigned less-than of two operands.
// Used for parent/node checks, root match and size ordering in turn.
// ----------------------------------------------------------------------------
module wuf_cmp #(
  parameter int unsigned WIDTH = 11
) (
  input  logic [WIDTH-1:0]       op_a_i,
  input  logic [WIDTH-1:0]       op_b_i,
  output wuf_pkg::cmp_res_t      res_o
);

  // Compare both ways at once
  always_comb begin
    res_o.eq = (op_a_i == op_b_i);
    res_o.lt = (op_a_i < op_b_i);
  end

endmodule

// ===== hw/rtl/weighted_union_find.sv =====
// ----------------------------------------------------------------------------
// weighted_union_find
// Weighted quick-union disjoint-set engine without path compression.
//
//  channel  dir  tdata fields (low bit up)           tuser      tlast
//  s_axis   in   first_element[9:0],                 operation  -
//                second_element[19:10], pad to 24
//  m_axis   out  same_set[0], pad to 8                -          -
//
// An item walks from the first element to its root, then from the second
// element to its root, matches the roots and, for a connect of two different
// sets, reads both sizes and links; the single read port of the parent RAM
// walks one link per cycle. Weighting keeps trees at most log2(N) deep.
// After reset a clearing pass over every element initializes both
// tables; s_axis_tready_o stays low meanwhile and while an item is at work.
// A result waits in the output register while m_axis_tready_i is low.
// ----------------------------------------------------------------------------
`include "weighted_union_find_macros.svh"

module weighted_union_find #(
  parameter int unsigned ELEMENT_COUNT = wuf_pkg::ELEMENT_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // first_element[9:0], second_element[19:10], zero pad
  input  logic [wuf_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // operation
  input  logic                             s_axis_tuser_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // same_set[0], zero pad
  output logic [wuf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i
);

  localparam int unsigned IDX_W  = $clog2(ELEMENT_COUNT);
  localparam int unsigned SIZE_W = $clog2(ELEMENT_COUNT + 1);
  localparam int unsigned FW     = wuf_pkg::FIELD_W;

  // Sequencer states
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HOP_A = 4'd2;
  localparam logic [3:0] S_HOP_B = 4'd3;
  localparam logic [3:0] S_ROOTS = 4'd4;
  localparam logic [3:0] S_SIZE  = 4'd5;
  localparam logic [3:0] S_LINK  = 4'd6;
  localparam logic [3:0] S_DONE  = 4'd7;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(ELEMENT_COUNT - 1);

  logic [3:0]        state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic              op_q, op_d;
  logic [IDX_W-1:0]  b_idx_q, b_idx_d;
  logic [IDX_W-1:0]  node_q, node_d;
  logic [IDX_W-1:0]  ra_q, ra_d;
  logic [IDX_W-1:0]  rb_q, rb_d;
  logic [SIZE_W-1:0] sa_q, sa_d;
  logic              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  logic              out_same_q, out_same_d;

  logic              accept;
  logic              in_range;
  logic [FW-1:0]     in_a;
  logic [FW-1:0]     in_b;
  logic              out_load;

  logic              pr_we;
  logic [IDX_W-1:0]  pr_waddr, pr_wdata, pr_raddr, pr_rdata;
  logic              sz_we;
  logic [IDX_W-1:0]  sz_waddr, sz_raddr;
  logic [SIZE_W-1:0] sz_wdata, sz_rdata;
  logic [SIZE_W-1:0] size_sum;

  logic [SIZE_W-1:0] cmp_a, cmp_b;
  wuf_pkg::cmp_res_t cmp_res;

  // Tables
  wuf_ram #(
    .DEPTH (ELEMENT_COUNT),
    .WIDTH (IDX_W)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (pr_waddr),
    .wdata_i (pr_wdata),
    .raddr_i (pr_raddr),
    .rdata_o (pr_rdata)
  );

  wuf_ram #(
    .DEPTH (ELEMENT_COUNT),
    .WIDTH (SIZE_W)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (sz_we),
    .waddr_i (sz_waddr),
    .wdata_i (sz_wdata),
    .raddr_i (sz_raddr),
    .rdata_o (sz_rdata)
  );

  // Shared compare unit
  wuf_cmp #(
    .WIDTH (SIZE_W)
  ) u_cmp (
    .op_a_i (cmp_a),
    .op_b_i (cmp_b),
    .res_o  (cmp_res)
  );

  // Unpack input fields
  assign in_a     = s_axis_tdata_i[FW-1:0];
  assign in_b     = s_axis_tdata_i[2*FW-1:FW];
  assign in_range = (32'(in_a) < 32'(ELEMENT_COUNT)) && (32'(in_b) < 32'(ELEMENT_COUNT));

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign size_sum        = sa_q + sz_rdata;
  assign out_load        = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);

  // Steer compare operands by state
  always_comb begin
    case (state_q)
      S_HOP_A, S_HOP_B: begin
        cmp_a = SIZE_W'(pr_rdata);
        cmp_b = SIZE_W'(node_q);
      end
      S_ROOTS: begin
        cmp_a = SIZE_W'(ra_q);
        cmp_b = SIZE_W'(rb_q);
      end
      S_LINK: begin
        cmp_a = sa_q;
        cmp_b = sz_rdata;
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    op_d     = op_q;
    b_idx_d  = b_idx_q;
    node_d   = node_q;
    ra_d     = ra_q;
    rb_d     = rb_q;
    sa_d     = sa_q;
    res_d    = res_q;
    pr_we    = 1'b0;
    pr_waddr = clr_q;
    pr_wdata = clr_q;
    pr_raddr = node_q;
    sz_we    = 1'b0;
    sz_waddr = clr_q;
    sz_wdata = SIZE_W'(1);
    sz_raddr = ra_q;

    case (state_q)
      // Make every element its own root of size one
      S_CLEAR: begin
        pr_we = 1'b1;
        sz_we = 1'b1;
        clr_d = clr_q + IDX_W'(1);
        if (clr_q == LastIdx) begin
          state_d = S_IDLE;
        end
      end
      // Take an item and start the first walk, or go to S_DONE with a false result if an index is out of range
      S_IDLE: begin
        if (accept) begin
          op_d     = s_axis_tuser_i;
          b_idx_d  = IDX_W'(in_b);
          node_d   = IDX_W'(in_a);
          pr_raddr = IDX_W'(in_a);
          if (in_range) begin
            state_d = S_HOP_A;
          end else begin
            res_d   = 1'b0;
            state_d = S_DONE;
          end
        end
      end
      // Walk from the first element; on its root start the second walk
      S_HOP_A: begin
        if (cmp_res.eq) begin
          ra_d     = node_q;
          node_d   = b_idx_q;
          pr_raddr = b_idx_q;
          state_d  = S_HOP_B;
        end else begin
          node_d   = pr_rdata;
          pr_raddr = pr_rdata;
        end
      end
      // Walk from the second element
      S_HOP_B: begin
        if (cmp_res.eq) begin
          rb_d    = node_q;
          state_d = S_ROOTS;
        end else begin
          node_d   = pr_rdata;
          pr_raddr = pr_rdata;
        end
      end
      // Match roots; a connect of two sets goes on to read sizes
      S_ROOTS: begin
        sz_raddr = ra_q;
        res_d    = cmp_res.eq;
        if (cmp_res.eq || (op_q == wuf_pkg::OP_FIND)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SIZE;
        end
      end
      // Hold the first size, fetch the second
      S_SIZE: begin
        sa_d     = sz_rdata;
        sz_raddr = rb_q;
        state_d  = S_LINK;
      end
      // Hang the smaller tree under the larger root
      S_LINK: begin
        pr_we    = 1'b1;
        sz_we    = 1'b1;
        sz_wdata = size_sum;
        if (cmp_res.lt) begin
          pr_waddr = ra_q;
          pr_wdata = rb_q;
          sz_waddr = rb_q;
        end else begin
          pr_waddr = rb_q;
          pr_wdata = ra_q;
          sz_waddr = ra_q;
        end
        state_d = S_DONE;
      end
      // Hand the result to the output register
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_same_d  = out_same_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_same_d  = res_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    b_idx_q    <= b_idx_d;
    node_q     <= node_d;
    ra_q       <= ra_d;
    rb_q       <= rb_d;
    sa_q       <= sa_d;
    res_q      <= res_d;
    out_same_q <= out_same_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(wuf_pkg::OUT_TDATA_W - 1){1'b0}}, out_same_q};

  // Checks
  `WUF_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, accept, (state_q == S_HOP_A) || (state_q == S_DONE))
  `WUF_ASSERT_IMP(a_link_no_self, clk_i, rst_ni, (state_q == S_LINK), pr_waddr != pr_wdata)
  `WUF_ASSERT_IMP(a_link_size_grows, clk_i, rst_ni, (state_q == S_LINK), sz_wdata >= SIZE_W'(2))

endmodule

// ===== verif/weighted_union_find_tb.sv =====
// ----------------------------------------------------------------------------
// weighted_union_find_tb
// Self-checking bench for the weighted union-find engine. A directed table of
// items covers the extremes, both operations, elements joined to themselves,
// repeated connects and trees of equal size. A random part follows: most
// items work inside a small window of elements so that trees grow deep, and
// the rest use the full index range. A local copy of the forest predicts
// same_set for every accepted item. Both stream sides idle at random. The
// receiver holds off once for a long stretch, and the sender pauses after the
// directed table and once in the random part until every result is in.
// ----------------------------------------------------------------------------
module weighted_union_find_tb;

  localparam int unsigned ELEMENTS     = wuf_pkg::ELEMENT_COUNT_DEF;
  localparam int unsigned FW           = wuf_pkg::FIELD_W;
  localparam int unsigned IN_W         = wuf_pkg::IN_TDATA_W;
  localparam int unsigned OUT_W        = wuf_pkg::OUT_TDATA_W;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic          op;
    logic [FW-1:0] first;
    logic [FW-1:0] second;
  } uf_item_t;

  typedef struct packed {
    uf_item_t item;
    logic     known;     // result given by hand below
    logic     same_set;
  } directed_row_t;

  localparam int unsigned DIRECTED_ROWS = 22;

  // Hand-typed results only where they follow at a glance
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{wuf_pkg::OP_FIND,    10'd0,    10'd1023}, 1'b1, 1'b0},  // fresh forest
    '{'{wuf_pkg::OP_FIND,    10'd5,    10'd5   }, 1'b1, 1'b1},  // element with itself
    '{'{wuf_pkg::OP_CONNECT, 10'd1023, 10'd1023}, 1'b1, 1'b1},  // connect with itself
    '{'{wuf_pkg::OP_CONNECT, 10'd0,    10'd1023}, 1'b1, 1'b0},
    '{'{wuf_pkg::OP_FIND,    10'd1023, 10'd0   }, 1'b1, 1'b1},
    '{'{wuf_pkg::OP_CONNECT, 10'd0,    10'd1023}, 1'b1, 1'b1},  // already joined
    '{'{wuf_pkg::OP_FIND,    10'd512,  10'd511 }, 1'b1, 1'b0},
    '{'{wuf_pkg::OP_CONNECT, 10'd1,    10'd2   }, 1'b0, 1'b0},
    '{'{wuf_pkg::OP_CONNECT, 10'd3,    10'd4   }, 1'b0, 1'b0},
    '{'{wuf_pkg::OP_CONNECT, 10'd1,    10'd3   }, 1'b0, 1'b0},  // equal sizes
    '{'{wuf_pkg::OP_FIND,    10'd4,    10'd2   }, 1'b0, 1'b0},
    '{'{wuf_pkg::OP_CONNECT, 10'd5,    10'd4   }, 1'b0, 1'b0},  // single under larger
    '{'{wuf_pkg::OP_CONNECT, 10'd1023, 10'd6   }, 1'b0, 1'b0},
    '{'{wuf_pkg::OP_CONNECT, 10'd4,    10'd0   }, 1'b0, 1'b0},
    '{'{wuf_pkg::OP_FIND,    10'd6,    10'd2   }, 1'b0, 1'b0},
    '{'{wuf_pkg::OP_FIND,    10'd682,  10'd341 }, 1'b0, 1'b0},
    '{'{wuf_pkg::OP_CONNECT, 10'd682,  10'd341 }, 1'b0, 1'b0},
    '{'{wuf_pkg::OP_FIND,    10'd341,  10'd682 }, 1'b0, 1'b0},
    '{'{wuf_pkg::OP_CONNECT, 10'd7,    10'd8   }, 1'b0, 1'b0},
    '{'{wuf_pkg::OP_CONNECT, 10'd9,    10'd8   }, 1'b0, 1'b0},
    '{'{wuf_pkg::OP_CONNECT, 10'd341,  10'd9   }, 1'b0, 1'b0},
    '{'{wuf_pkg::OP_FIND,    10'd7,    10'd1023}, 1'b0, 1'b0}
  };

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic [IN_W-1:0]  s_tdata         = '0;
  logic             s_tuser         = 1'b0;
  logic             s_tvalid        = 1'b0;
  logic             s_tready;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tvalid;
  logic             m_tready        = 1'b0;

  // Shared control of the idling pattern
  bit          calm       = 1'b0;
  bit          hold_req   = 1'b0;
  int unsigned err_count  = 0;
  int unsigned cycle_count = 0;

  // Local copy of the forest and the queue of pending same_set values
  logic [FW-1:0] forest_parent [ELEMENTS];
  logic [FW:0]   forest_size   [ELEMENTS];
  logic          same_set_q [$];

  weighted_union_find dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Follow parent links up to the root, bounded by the element count
  function automatic logic [FW-1:0] root_of(logic [FW-1:0] node);
    int unsigned hops;
    hops = 0;
    while (hops < ELEMENTS && forest_parent[node] != node) begin
      node = forest_parent[node];
      hops++;
    end
    return node;
  endfunction

  // Compare roots and, for a connect of two sets, link smaller under larger.
  // Indices are 10 bits wide, so they never exceed the element count here.
  function automatic logic union_or_query(uf_item_t it);
    logic [FW-1:0] root_a;
    logic [FW-1:0] root_b;
    root_a = root_of(it.first);
    root_b = root_of(it.second);
    if (root_a == root_b) return 1'b1;
    if (it.op == wuf_pkg::OP_CONNECT) begin
      if (forest_size[root_a] < forest_size[root_b]) begin
        forest_parent[root_a] = root_b;
        forest_size[root_b]   = forest_size[root_b] + forest_size[root_a];
      end else begin
        // equal sizes land here: second root goes under the first
        forest_parent[root_b] = root_a;
        forest_size[root_a]   = forest_size[root_a] + forest_size[root_b];
      end
    end
    return 1'b0;
  endfunction

  // Mostly a small window of elements so that trees grow deep
  function automatic uf_item_t random_item(logic [FW-1:0] lo);
    uf_item_t    it;
    int unsigned pick;
    pick  = $urandom_range(99);
    it.op = ($urandom_range(99) < 55) ? wuf_pkg::OP_CONNECT : wuf_pkg::OP_FIND;
    if (pick < 65) begin
      it.first  = FW'(lo + $urandom_range(63));
      it.second = FW'(lo + $urandom_range(63));
    end else if (pick < 85) begin
      it.first  = FW'($urandom_range(ELEMENTS - 1));
      it.second = FW'($urandom_range(ELEMENTS - 1));
    end else if (pick < 92) begin
      it.first  = FW'($urandom_range(ELEMENTS - 1));
      it.second = it.first;
    end else begin
      it.first  = ($urandom_range(1) != 0) ? FW'(ELEMENTS - 1) : '0;
      it.second = FW'(lo + $urandom_range(63));
    end
    return it;
  endfunction

  // Offer one item, after a random gap unless calm; predict once it is accepted
  task automatic send_item(uf_item_t it, logic known, logic typed_same);
    logic predicted;
    @(negedge clk_i);
    if (!calm) begin
      while ($urandom_range(99) < 34) begin
        s_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {{(IN_W - 2 * FW){1'b0}}, it.second, it.first};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predicted = union_or_query(it);
    same_set_q.push_back(known ? typed_same : predicted);
  endtask

  task automatic wait_drained();
    while (same_set_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : drain_side
    int unsigned held;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk_i);
          held++;
        end
        hold_req = 1'b0;
      end
      m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
    end
  end

  // Check each result against the oldest pending value
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      if (same_set_q.size() == 0) begin
        $display("%0t: unexpected result, same_set %0b", $time, m_tdata[0]);
        err_count++;
      end else begin
        if (m_tdata[0] !== same_set_q[0]) begin
          $display("%0t: same_set mismatch, expected %0b, actual %0b",
                   $time, same_set_q[0], m_tdata[0]);
          err_count++;
        end
        void'(same_set_q.pop_front());
      end
    end
  end

  // Guard against a hung block
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("weighted_union_find_tb: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [FW-1:0] window_lo;
    uf_item_t      it;
    for (int k = 0; k < ELEMENTS; k++) begin
      forest_parent[k] = FW'(k);
      forest_size[k]   = (FW + 1)'(1);
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_item(directed_rows[r].item, directed_rows[r].known,
                directed_rows[r].same_set);
    end

    // Hold the sender until the block has emptied
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    wait_drained();

    window_lo = '0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Move the working window now and then, touching both ends
      if (n % 150 == 0) begin
        case ($urandom_range(3))
          0:       window_lo = '0;
          1:       window_lo = FW'(ELEMENTS - 64);
          default: window_lo = FW'($urandom_range(ELEMENTS - 64));
        endcase
      end
      calm = (n >= 200 && n < 350);
      if (n == 400) hold_req = 1'b1;
      if (n == 550) begin
        @(negedge clk_i);
        s_tvalid <= 1'b0;
        wait_drained();
      end
      it = random_item(window_lo);
      send_item(it, 1'b0, 1'b0);
    end

    @(negedge clk_i);
    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("weighted_union_find_tb: done, clean");
    end else begin
      $display("weighted_union_find_tb: done, errors");
    end
    $finish;
  end

endmodule
